// ===== hdl/uart_baud_divisor_calculator_macros.svh =====
// Assertion macros for the UART baud divisor calculator.
// Used by the top level only; needs no package.
`ifndef UART_BAUD_DIVISOR_CALCULATOR_MACROS_SVH
`define UART_BAUD_DIVISOR_CALCULATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check an implication within the same cycle.
`define UBDC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ubdc check failed");
// Check an implication in the next cycle.
`define UBDC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ubdc check failed");
`else
`define UBDC_ASSERT(lbl, ante, cons)
`define UBDC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/ubdc_pkg.sv =====
// Shared types, constants and ROM functions for the UART baud divisor calculator.
// No dependencies.
package ubdc_pkg;

  localparam int unsigned RATE_W      = 32;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned DIVIDEND_W  = RATE_W + FRAC_W;
  localparam int unsigned DIV_STEPS   = DIVIDEND_W;
  localparam int unsigned ROM_ENTRIES = 36;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned BIT_W       = 3;
  localparam int unsigned SEARCH_STEPS = IDX_W;
  localparam int unsigned CNT_W       = 6;
  localparam logic [RATE_W-1:0] OS_LIMIT = RATE_W'(16);

  typedef struct packed {
    logic [RATE_W-1:0] src_clk_hz;
    logic [RATE_W-1:0] line_bps;
  } in_beat_t;

  typedef struct packed {
    logic [27:0] divider;
    logic        oversample_16x;
    logic [3:0]  first_stage_pattern;
    logic [7:0]  mod_byte;
    logic [15:0] modulation_control_word;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic step;
  } unit_ctrl_t;

  function automatic logic [FRAC_W-1:0] thresh_at(input logic [IDX_W-1:0] idx);
    logic [FRAC_W-1:0] t;
    unique case (idx)
      6'd0:  t = 16'd0;     6'd1:  t = 16'd3466;  6'd2:  t = 16'd4685;
      6'd3:  t = 16'd5472;  6'd4:  t = 16'd6560;  6'd5:  t = 16'd8205;
      6'd6:  t = 16'd9371;  6'd7:  t = 16'd10944; 6'd8:  t = 16'd14070;
      6'd9:  t = 16'd14575; 6'd10: t = 16'd16403; 6'd11: t = 16'd19660;
      6'd12: t = 16'd21856; 6'd13: t = 16'd23429; 6'd14: t = 16'd24595;
      6'd15: t = 16'd26234; 6'd16: t = 16'd28088; 6'd17: t = 16'd28691;
      6'd18: t = 16'd32781; 6'd19: t = 16'd37453; 6'd20: t = 16'd39341;
      6'd21: t = 16'd40986; 6'd22: t = 16'd42152; 6'd23: t = 16'd43692;
      6'd24: t = 16'd45881; 6'd25: t = 16'd46838; 6'd26: t = 16'd49171;
      6'd27: t = 16'd51517; 6'd28: t = 16'd52455; 6'd29: t = 16'd54611;
      6'd30: t = 16'd55469; 6'd31: t = 16'd56177; 6'd32: t = 16'd57350;
      6'd33: t = 16'd59008; 6'd34: t = 16'd60096; 6'd35: t = 16'd60869;
      default: t = 16'hFFFF;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] pattern_at(input logic [IDX_W-1:0] idx);
    logic [7:0] p;
    unique case (idx)
      6'd0:  p = 8'h00; 6'd1:  p = 8'h01; 6'd2:  p = 8'h02; 6'd3:  p = 8'h04;
      6'd4:  p = 8'h08; 6'd5:  p = 8'h10; 6'd6:  p = 8'h20; 6'd7:  p = 8'h11;
      6'd8:  p = 8'h21; 6'd9:  p = 8'h22; 6'd10: p = 8'h44; 6'd11: p = 8'h25;
      6'd12: p = 8'h49; 6'd13: p = 8'h4A; 6'd14: p = 8'h52; 6'd15: p = 8'h92;
      6'd16: p = 8'h53; 6'd17: p = 8'h55; 6'd18: p = 8'hAA; 6'd19: p = 8'h6B;
      6'd20: p = 8'hAD; 6'd21: p = 8'hB5; 6'd22: p = 8'hB6; 6'd23: p = 8'hD6;
      6'd24: p = 8'hB7; 6'd25: p = 8'hBB; 6'd26: p = 8'hDD; 6'd27: p = 8'hED;
      6'd28: p = 8'hEE; 6'd29: p = 8'hBF; 6'd30: p = 8'hDF; 6'd31: p = 8'hEF;
      6'd32: p = 8'hF7; 6'd33: p = 8'hFB; 6'd34: p = 8'hFD; 6'd35: p = 8'hFE;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/ubdc_div.sv =====
// Restoring divider, one quotient bit per step: {src_clk_hz, 16'b0} / line_bps.
// Depends on ubdc_pkg.
module ubdc_div (
  input  logic                                clk,
  input  ubdc_pkg::unit_ctrl_t                ctrl,
  input  logic [ubdc_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [ubdc_pkg::RATE_W-1:0]         divisor,
  output logic [ubdc_pkg::DIVIDEND_W-1:0]     quotient
);
  import ubdc_pkg::*;

  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [RATE_W-1:0]     rem_r, rem_nxt;
  logic [RATE_W-1:0]     dvs_r;
  logic [RATE_W:0]       trial;
  logic [RATE_W+1:0]     diff;
  logic                  fits;

  // Bring down the next dividend bit and try the subtract.
  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_W-1]};
    diff    = {1'b0, trial} - {2'b00, dvs_r};
    fits    = ~diff[RATE_W+1];
    rem_nxt = fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
    quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (ctrl.step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;

endmodule

// ===== hdl/ubdc_msel.sv =====
// Modulation byte picker: bitwise binary search of the threshold ROM.
// Depends on ubdc_pkg.
module ubdc_msel (
  input  logic                          clk,
  input  ubdc_pkg::unit_ctrl_t          ctrl,
  input  logic [ubdc_pkg::FRAC_W-1:0]   frac,
  output logic [7:0]                    pattern
);
  import ubdc_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [BIT_W-1:0] bit_r;
  logic [IDX_W-1:0] cand;
  logic             take;

  // Set the next lower index bit when its threshold is still at or below the fraction.
  always_comb begin
    cand    = idx_r | (IDX_W'(1) << bit_r);
    take    = (cand < IDX_W'(ROM_ENTRIES)) && (thresh_at(cand) <= frac);
    idx_nxt = take ? cand : idx_r;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      idx_r <= '0;
      bit_r <= BIT_W'(IDX_W - 1);
    end else if (ctrl.step) begin
      idx_r <= idx_nxt;
      bit_r <= bit_r - BIT_W'(1);
    end
  end

  assign pattern = pattern_at(idx_r);

endmodule

// ===== hdl/uart_baud_divisor_calculator.sv =====
// UART baud divisor calculator, top level.
// Sequence: the accepting edge loads the divider; then come 48 divide steps, 6 search steps,
// the pack state and the output register. A zero baud rate goes from idle straight to packing.
// A new item is accepted only while idle, so items never overlap in the one-bit-per-cycle divider.
// Reset: synchronous, active low; returns the sequencer to idle and drops the strobe.
// The receiver cannot stall: each result is shown for one cycle only.
`include "uart_baud_divisor_calculator_macros.svh"
module uart_baud_divisor_calculator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ubdc_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  output ubdc_pkg::out_beat_t  out_data
);
  import ubdc_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIVIDE = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              zero_baud_r;
  logic              accept;
  unit_ctrl_t        div_ctrl;
  unit_ctrl_t        sel_ctrl;
  logic [DIVIDEND_W-1:0] quotient;
  logic [RATE_W-1:0] n_quo;
  logic [FRAC_W-1:0] frac;
  logic [7:0]        mod_pat;
  out_beat_t         res;
  logic              out_valid_r;
  out_beat_t         out_data_r;
  logic              out_direct_ok;
  logic              out_word_ok;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start & ~busy;

  // Split the 48-bit quotient: top 32 bits are N, bottom 16 the fraction.
  assign n_quo = quotient[DIVIDEND_W-1:FRAC_W];
  assign frac  = quotient[FRAC_W-1:0];

  ubdc_div u_div (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend ({in_data.src_clk_hz, {FRAC_W{1'b0}}}),
    .divisor  (in_data.line_bps),
    .quotient (quotient)
  );

  ubdc_msel u_msel (
    .clk     (clk),
    .ctrl    (sel_ctrl),
    .frac    (frac),
    .pattern (mod_pat)
  );

  // Sequencer: load the divider on accept, step it, then step the ROM search.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    div_ctrl.load = 1'b0;
    div_ctrl.step = 1'b0;
    sel_ctrl.load = 1'b0;
    sel_ctrl.step = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          div_ctrl.load = 1'b1;
          cnt_nxt       = '0;
          // A zero baud rate skips the arithmetic and gives an all-zero result.
          state_nxt     = (in_data.line_bps == '0) ? ST_DONE : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        div_ctrl.step = 1'b1;
        cnt_nxt       = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          sel_ctrl.load = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        sel_ctrl.step = 1'b1;
        cnt_nxt       = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SEARCH_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Pack the result: all zero for a zero baud rate, else direct mode up to N of 16, else 16x oversampling.
  always_comb begin
    res = '0;
    if (!zero_baud_r) begin
      if (n_quo <= OS_LIMIT) begin
        res.divider             = n_quo[27:0];
        res.oversample_16x      = 1'b0;
        res.first_stage_pattern = 4'h0;
      end else begin
        res.divider             = n_quo[RATE_W-1:4];
        res.oversample_16x      = 1'b1;
        res.first_stage_pattern = n_quo[3:0];
      end
      res.mod_byte                = mod_pat;
      res.modulation_control_word = {mod_pat, res.first_stage_pattern, 3'b000,
                                     res.oversample_16x};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (state_r == ST_DONE);
    end
  end

  // Hold the zero-baud flag per item and register the outgoing beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      zero_baud_r <= (in_data.line_bps == '0);
    end
    if (state_r == ST_DONE) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Direct mode never carries a first-stage pattern or a divider above 16.
  assign out_direct_ok = (out_data_r.first_stage_pattern == 4'h0) &&
                         (out_data_r.divider <= 28'd16);
  assign out_word_ok   = (out_data_r.modulation_control_word[15:8] == out_data_r.mod_byte) &&
                         (out_data_r.modulation_control_word[0] == out_data_r.oversample_16x);

  `UBDC_ASSERT_NXT(a_accept_busy, accept, busy)
  `UBDC_ASSERT_NXT(a_strobe_single, out_valid, !out_valid)
  `UBDC_ASSERT(a_direct_mode, out_valid && !out_data.oversample_16x, out_direct_ok)
  `UBDC_ASSERT(a_word_packed, out_valid, out_word_ok)

endmodule
